### hw/rtl/http_get_query_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request parser.
// Each macro checks a property on the rising clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_GET_QUERY_PARSER_ASSERT_SVH
`define HTTP_GET_QUERY_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define HGQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HGQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define HGQ_ASSERT(label, clk, rst_n, prop, msg)
`define HGQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

### hw/rtl/hgq_pkg.sv
// ----------------------------------------------------------------------------
// hgq_pkg
// Shared types and constants of the request parser.
// ----------------------------------------------------------------------------
package hgq_pkg;

	localparam int MSG_BYTES_DEF = 32;
	localparam int MARK_LEN = 9;

	typedef enum logic [4:0] {
		PH_PREFIX = 5'b00001,
		PH_PATH   = 5'b00010,
		PH_QUERY  = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_FAIL   = 5'b10000
	} phase_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic take;    // process one input byte
		logic restart; // clear message state
		logic [4:0] rd_idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ok;
		logic [7:0] ident;
		logic [4:0] len;
		logic [7:0] rd_byte;
	} dp_stat_t;

	function automatic logic [7:0] mark_char(input logic [3:0] i);
		case (i)
			4'd0: mark_char = 8'h20;
			4'd1: mark_char = 8'h48;
			4'd2: mark_char = 8'h54;
			4'd3: mark_char = 8'h54;
			4'd4: mark_char = 8'h50;
			4'd5: mark_char = 8'h2F;
			4'd6: mark_char = 8'h31;
			4'd7: mark_char = 8'h2E;
			4'd8: mark_char = 8'h31;
			default: mark_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] get_char(input logic [1:0] i);
		case (i)
			2'd0: get_char = 8'h47;
			2'd1: get_char = 8'h45;
			2'd2: get_char = 8'h54;
			default: get_char = 8'h20;
		endcase
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

### hw/rtl/http_get_query_parser.sv
// ----------------------------------------------------------------------------
// http_get_query_parser
// Byte-serial HTTP GET query parser with a command byte output stream.
// ----------------------------------------------------------------------------
// Input: s_axis carries one request byte per beat in tdata and the
// end-of-message flag in tlast. One beat is taken per cycle while parsing.
// Output: m_axis carries result beats; tuser is the kind (0 command byte,
// 1 summary) and tlast marks the summary that ends the run. tdata holds,
// from bit 0 up, command_byte, accepted, ident, command_length.
// Sequence: after the tlast input beat the block waits in WAIT while the
// deferred id decode settles, then latches the summary. The first stored
// command byte is then offered at once and each further one only after
// valid has been low while the registered buffer read port catches up;
// the summary follows in the cycle after the last command byte is taken.
// Input is not taken while the result run plays out.
// Reset clears all control state; the command buffer needs no clearing.
// A stall on m_axis holds the current beat until it is taken.
module http_get_query_parser #(
	parameter int MSG_BYTES = hgq_pkg::MSG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata, // text_byte
	input  logic s_axis_tlast,       // end_of_message
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // command_byte, accepted, ident, command_length
	output logic m_axis_tuser,        // kind
	output logic m_axis_tlast         // final_item
);
	import hgq_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [31:0] od;

	hgq_datapath #(.MSG_BYTES(MSG_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .text_byte(s_axis_tdata), .cmd(cmd), .stat(stat)
	);

	hgq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_last(s_axis_tlast), .stat(stat), .cmd(cmd), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_data(od), .out_user(m_axis_tuser)
	);

	assign m_axis_tdata = od[22:0] == 23'd0 ? 24'd0 : {1'b0, od[22:0]};
	assign m_axis_tlast = od[23];

endmodule

### hw/rtl/hgq_datapath.sv
// ----------------------------------------------------------------------------
// hgq_datapath
// Prefix check, marker window, query pair parsing and command storage.
// ----------------------------------------------------------------------------
module hgq_datapath #(
	parameter int MSG_BYTES = hgq_pkg::MSG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] text_byte,
	input  hgq_pkg::dp_cmd_t cmd,
	output hgq_pkg::dp_stat_t stat
);
	import hgq_pkg::*;

	localparam int CMD_CAP = (MSG_BYTES - 1) > 31 ? 31 : (MSG_BYTES - 1);

	phase_t phase_q;
	logic [2:0] prefix_count_q;
	logic [7:0] win_q [MARK_LEN];
	logic [3:0] fill_q;
	logic [1:0] key_length_q, key_class_q;
	logic [5:0] value_length_q;
	logic in_value_q, text_ended_q;
	logic [7:0] id_chars_q [3];
	logic [7:0] ident_q;
	logic [7:0] cmd_mem [31];
	logic [4:0] count_q;
	logic [7:0] rd_q;

	// Next-state values.
	phase_t ph_n;
	logic [1:0] kl_n, kc_n;
	logic [5:0] vl_n;
	logic iv_n;
	logic [7:0] id_n;
	logic [4:0] cnt_n;
	logic wr_id, wr_cmd, shift, hit;
	logic [7:0] c;

	// Decode of the stored id characters.
	logic id_ok;
	logic [7:0] id_val;
	always_comb begin
		logic [1:0] i;
		logic neg, bad, sg;
		logic [9:0] v;
		logic [1:0] dg;
		i = 2'd0; neg = 1'b0; v = 10'd0; dg = 2'd0; bad = 1'b0; sg = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (k == int'(i) && i < value_length_q[1:0] && is_blank(id_chars_q[k]))
				i = i + 2'd1;
		end
		// At most one sign may follow the blanks.
		for (int k = 0; k < 3; k++) begin
			if (!sg && k == int'(i) && i < value_length_q[1:0] &&
			    (id_chars_q[k] == 8'h2B || id_chars_q[k] == 8'h2D)) begin
				neg = (id_chars_q[k] == 8'h2D);
				sg = 1'b1;
				i = i + 2'd1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (k >= int'(i) && k < int'(value_length_q[1:0]) && !bad) begin
				if (is_digit(id_chars_q[k])) begin
					v = 10'((v * 10) + 10'(id_chars_q[k] - 8'h30));
					dg = dg + 2'd1;
				end else begin
					bad = 1'b1;
				end
			end
		end
		id_ok = !bad && dg != 2'd0 && !(neg && v != 10'd0) && v <= 10'd255 &&
		        value_length_q < 6'd4;
		id_val = v[7:0];
	end

	always_comb begin
		logic is_id, is_cmd;
		ph_n = phase_q; kl_n = key_length_q; kc_n = key_class_q;
		vl_n = value_length_q; iv_n = in_value_q; id_n = ident_q; cnt_n = count_q;
		wr_id = 1'b0; wr_cmd = 1'b0; shift = 1'b0; hit = 1'b0;
		c = win_q[0];
		is_id = key_class_q == 2'd1 && key_length_q == 2'd2;
		is_cmd = key_class_q == 2'd2 && key_length_q == 2'd3;
		if (fill_q >= 4'(MARK_LEN)) begin
			shift = 1'b1;
			if (phase_q == PH_PATH) begin
				if (c == 8'h3F) begin
					ph_n = PH_QUERY; iv_n = 1'b0; kl_n = 2'd0; kc_n = 2'd0; vl_n = 6'd0;
				end
			end else if (!in_value_q) begin
				if (c == 8'h3D) begin
					if (key_length_q == 2'd0) ph_n = PH_FAIL;
					else begin iv_n = 1'b1; vl_n = 6'd0; end
				end else if (c == 8'h26) begin
					ph_n = PH_FAIL;
				end else begin
					if (key_length_q == 2'd0)
						kc_n = c == 8'h69 ? 2'd1 : (c == 8'h63 ? 2'd2 : 2'd0);
					else if (key_class_q == 2'd1)
						kc_n = (key_length_q == 2'd1 && c == 8'h64) ? 2'd1 : 2'd0;
					else if (key_class_q == 2'd2)
						kc_n = ((key_length_q == 2'd1 && c == 8'h6D) ||
						        (key_length_q == 2'd2 && c == 8'h64)) ? 2'd2 : 2'd0;
					if (key_length_q < 2'd3) kl_n = key_length_q + 2'd1;
				end
			end else if (c == 8'h26) begin
				if (value_length_q == 6'd0 || (is_id && !id_ok)) ph_n = PH_FAIL;
				else begin
					if (is_id) id_n = id_val;
					else if (is_cmd)
						cnt_n = value_length_q < 6'(CMD_CAP) ? value_length_q[4:0]
						                                     : 5'(CMD_CAP);
					iv_n = 1'b0; kl_n = 2'd0; kc_n = 2'd0; vl_n = 6'd0;
				end
			end else begin
				wr_id = is_id && value_length_q < 6'd3;
				wr_cmd = is_cmd && value_length_q < 6'(CMD_CAP);
				if (value_length_q < 6'd63) vl_n = value_length_q + 6'd1;
			end
		end
		// Marker check on the window as it will stand after this byte.
		if (ph_n != PH_FAIL && fill_q >= 4'(MARK_LEN - 1)) begin
			hit = text_byte == mark_char(4'(MARK_LEN - 1));
			for (int k = 0; k < MARK_LEN - 1; k++)
				if ((shift ? win_q[k + 1] : win_q[k]) != mark_char(4'(k))) hit = 1'b0;
		end
		if (hit) begin
			if (ph_n == PH_PATH) ph_n = PH_FAIL;
			else if (iv_n) begin
				if (vl_n == 6'd0) ph_n = PH_FAIL;
				else if (kc_n == 2'd1 && kl_n == 2'd2) begin
					// id value ending at the marker; decode matches stored state
					// only when no byte was committed this step into it.
					ph_n = PH_FAIL;
				end else begin
					if (kc_n == 2'd2 && kl_n == 2'd3)
						cnt_n = vl_n < 6'(CMD_CAP) ? vl_n[4:0] : 5'(CMD_CAP);
					ph_n = PH_DONE;
				end
			end else if (kl_n != 2'd0) ph_n = PH_FAIL;
			else ph_n = PH_DONE;
		end
	end

	// An id pair that ends at the marker needs the decode of the final
	// character too; it is resolved in the following cycle through this flag.
	logic idend_q;
	logic idend_n;
	assign idend_n = hit && ph_n == PH_FAIL && iv_n && vl_n != 6'd0 &&
	                 kc_n == 2'd1 && kl_n == 2'd2 && phase_q != PH_PATH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; prefix_count_q <= 3'd0; fill_q <= 4'd0;
			key_length_q <= 2'd0; key_class_q <= 2'd0; value_length_q <= 6'd0;
			in_value_q <= 1'b0; text_ended_q <= 1'b0; ident_q <= 8'd0;
			count_q <= 5'd0; idend_q <= 1'b0;
			for (int k = 0; k < MARK_LEN; k++) win_q[k] <= 8'd0;
		end else if (cmd.restart) begin
			phase_q <= PH_PREFIX; prefix_count_q <= 3'd0; fill_q <= 4'd0;
			key_length_q <= 2'd0; key_class_q <= 2'd0; value_length_q <= 6'd0;
			in_value_q <= 1'b0; text_ended_q <= 1'b0; ident_q <= 8'd0;
			count_q <= 5'd0; idend_q <= 1'b0;
		end else if (idend_q) begin
			idend_q <= 1'b0;
			if (id_ok) begin ident_q <= id_val; phase_q <= PH_DONE; end
		end else if (cmd.take && !text_ended_q && phase_q != PH_DONE &&
		             phase_q != PH_FAIL) begin
			if (text_byte == 8'd0) begin
				text_ended_q <= 1'b1; phase_q <= PH_FAIL;
			end else if (phase_q == PH_PREFIX) begin
				if (text_byte != get_char(prefix_count_q[1:0])) phase_q <= PH_FAIL;
				else begin
					prefix_count_q <= prefix_count_q + 3'd1;
					if (prefix_count_q == 3'd3) phase_q <= PH_PATH;
				end
			end else begin
				phase_q <= idend_n ? PH_FAIL : ph_n;
				idend_q <= idend_n;
				key_length_q <= kl_n; key_class_q <= kc_n; value_length_q <= vl_n;
				in_value_q <= iv_n; ident_q <= id_n; count_q <= cnt_n;
				if (ph_n != PH_FAIL || idend_n) begin
					if (shift) begin
						for (int k = 0; k < MARK_LEN - 1; k++) win_q[k] <= win_q[k + 1];
						win_q[MARK_LEN - 1] <= text_byte;
					end else begin
						win_q[fill_q] <= text_byte;
						fill_q <= fill_q + 4'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !cmd.restart && !idend_q && phase_q != PH_PREFIX &&
		    text_byte != 8'd0 && !text_ended_q && phase_q != PH_DONE &&
		    phase_q != PH_FAIL) begin
			if (wr_id) id_chars_q[value_length_q[1:0]] <= c;
			if (wr_cmd) cmd_mem[value_length_q[4:0]] <= c;
		end
		rd_q <= cmd_mem[cmd.rd_idx];
	end

	assign stat.ok = phase_q == PH_DONE && count_q != 5'd0;
	assign stat.ident = ident_q;
	assign stat.len = count_q;
	assign stat.rd_byte = rd_q;

endmodule

### hw/rtl/hgq_ctrl.sv
// ----------------------------------------------------------------------------
// hgq_ctrl
// Sequencer: takes bytes, then plays out the command bytes and the summary.
// ----------------------------------------------------------------------------
`include "http_get_query_parser_assert.svh"
module hgq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_last,
	input  hgq_pkg::dp_stat_t stat,
	output hgq_pkg::dp_cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] out_data,
	output logic out_user
);
	import hgq_pkg::*;

	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_SUM  = 4'b1000
	} st_t;

	st_t st_q;
	logic [4:0] idx_q;
	logic ok_q;
	logic [7:0] id_q;
	logic [4:0] len_q;
	logic [1:0] wait_q;

	assign in_ready = st_q == ST_RUN;
	assign cmd.take = in_valid && in_ready;
	assign cmd.restart = st_q == ST_SUM && out_ready;
	assign cmd.rd_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN; idx_q <= 5'd0; wait_q <= 2'd0;
			ok_q <= 1'b0; id_q <= 8'd0; len_q <= 5'd0;
		end else begin
			case (st_q)
				ST_RUN: if (cmd.take && in_last) begin
					// Point the read port at the first byte while the summary settles.
					st_q <= ST_WAIT; wait_q <= 2'd0; idx_q <= 5'd0;
				end
				ST_WAIT: begin
					// Let the deferred id decode settle, then latch the summary.
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd1) begin
						ok_q <= stat.ok;
						id_q <= stat.ok ? stat.ident : 8'd0;
						len_q <= stat.ok ? stat.len : 5'd0;
						idx_q <= 5'd0;
						st_q <= stat.ok ? ST_EMIT : ST_SUM;
					end
				end
				ST_EMIT: if (out_valid && out_ready) begin
					if (idx_q + 5'd1 == len_q) st_q <= ST_SUM;
					idx_q <= idx_q + 5'd1;
				end
				ST_SUM: if (out_ready) st_q <= ST_RUN;
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// The memory read is registered, so the byte at idx_q reaches rd_q only
	// through that register; EMIT holds valid low on the cycle right after an advance.
	logic fresh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fresh_q <= 1'b0;
		else fresh_q <= (st_q == ST_EMIT && !(out_valid && out_ready)) ||
		                st_q == ST_WAIT;
	end

	logic emit_v;
	assign emit_v = st_q == ST_EMIT && fresh_q;
	assign out_valid = emit_v || st_q == ST_SUM;
	assign out_user = st_q == ST_SUM;
	assign out_data = {9'd0, 1'b0, len_q, id_q, ok_q, (emit_v ? stat.rd_byte : 8'd0)} |
	                  {8'd0, st_q == ST_SUM, 23'd0};

	`HGQ_ASSERT(a_ready_run, clk, arst_n, !in_ready || !out_valid, "input taken while emitting")
	`HGQ_ASSERT_NEXT(a_sum_end, clk, arst_n, st_q == ST_SUM && out_ready, in_ready,
		"no return to input after summary")
	`HGQ_ASSERT(a_idx, clk, arst_n, st_q != ST_EMIT || idx_q < len_q, "emit index overrun")

endmodule

### sim/http_get_query_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_get_query_parser_checker
// Watches both stream channels of the request parser. It keeps its own copy
// of the parser state, predicts the result beats of every message and
// compares each output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module http_get_query_parser_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic m_axis_tuser,
	input  logic m_axis_tlast,
	output int errors,
	output int pending,
	output int runs_accepted,
	output int runs_rejected
);
	import hgq_pkg::*;

	localparam int CMD_CAP = 31;
	localparam logic [1:0] KEY_OTHER = 2'd0;
	localparam logic [1:0] KEY_ID = 2'd1;
	localparam logic [1:0] KEY_CMD = 2'd2;

	typedef struct packed {
		logic kind;
		logic [7:0] cmd_byte;
		logic accepted;
		logic [7:0] ident;
		logic [4:0] cmd_len;
		logic final_item;
	} result_t;

	result_t result_q[$];

	const logic [7:0] get_prefix[4] = '{8'h47, 8'h45, 8'h54, 8'h20};
	const logic [7:0] http_marker[9] = '{8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31,
		8'h2E, 8'h31};

	phase_t phase;
	int prefix_seen;
	logic [7:0] window[9];
	int window_fill;
	int key_len;
	logic [1:0] key_class;
	int val_len;
	logic in_val;
	logic [7:0] id_text[3];
	logic [7:0] ident_val;
	logic [7:0] cmd_store[CMD_CAP];
	int cmd_count;
	logic text_ended;

	function automatic void clear_pair();
		in_val = 1'b0;
		key_len = 0;
		key_class = KEY_OTHER;
		val_len = 0;
	endfunction

	function automatic void clear_message();
		phase = PH_PREFIX;
		prefix_seen = 0;
		for (int i = 0; i < 9; i++) window[i] = 8'h00;
		window_fill = 0;
		clear_pair();
		ident_val = 8'h00;
		cmd_count = 0;
		text_ended = 1'b0;
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Decimal conversion in the manner of strtol: blanks, one sign, digits,
	// and nothing after the digits.
	function automatic logic id_decode(input int n, output logic [7:0] v);
		int i;
		logic neg;
		int acc;
		int digits;
		i = 0;
		neg = 1'b0;
		acc = 0;
		digits = 0;
		v = 8'h00;
		while (i < n && blank(id_text[i])) i++;
		if (i < n && (id_text[i] == "+" || id_text[i] == "-")) begin
			neg = (id_text[i] == "-");
			i++;
		end
		while (i < n && id_text[i] >= "0" && id_text[i] <= "9") begin
			acc = acc * 10 + (id_text[i] - "0");
			digits++;
			i++;
		end
		if (digits == 0 || i != n) return 1'b0;
		if (neg && acc != 0) return 1'b0;
		if (acc > 255) return 1'b0;
		v = acc[7:0];
		return 1'b1;
	endfunction

	function automatic void close_pair();
		logic [7:0] v;
		if (val_len == 0) begin
			phase = PH_FAIL;
			return;
		end
		if (key_class == KEY_ID && key_len == 2) begin
			if (val_len >= 4 || !id_decode(val_len, v)) begin
				phase = PH_FAIL;
				return;
			end
			ident_val = v;
		end else if (key_class == KEY_CMD && key_len == 3) begin
			cmd_count = (val_len < CMD_CAP) ? val_len : CMD_CAP;
		end
		clear_pair();
	endfunction

	// One URI byte leaves the lookback window and is interpreted here.
	function automatic void uri_byte(input logic [7:0] c);
		if (phase == PH_PATH) begin
			if (c == "?") begin
				phase = PH_QUERY;
				clear_pair();
			end
			return;
		end
		if (!in_val) begin
			if (c == "=") begin
				if (key_len == 0) begin
					phase = PH_FAIL;
					return;
				end
				in_val = 1'b1;
				val_len = 0;
			end else if (c == "&") begin
				phase = PH_FAIL;
			end else begin
				if (key_len == 0)
					key_class = (c == "i") ? KEY_ID : ((c == "c") ? KEY_CMD : KEY_OTHER);
				else if (key_class == KEY_ID)
					key_class = (key_len == 1 && c == "d") ? KEY_ID : KEY_OTHER;
				else if (key_class == KEY_CMD)
					key_class = ((key_len == 1 && c == "m") || (key_len == 2 && c == "d"))
						? KEY_CMD : KEY_OTHER;
				if (key_len < 3) key_len++;
			end
			return;
		end
		if (c == "&") begin
			close_pair();
			return;
		end
		if (key_class == KEY_ID && key_len == 2 && val_len < 3) id_text[val_len] = c;
		if (key_class == KEY_CMD && key_len == 3 && val_len < CMD_CAP) cmd_store[val_len] = c;
		if (val_len < 63) val_len++;
	endfunction

	function automatic void close_uri();
		if (phase == PH_PATH) begin
			phase = PH_FAIL;
			return;
		end
		if (in_val) close_pair();
		else if (key_len > 0) phase = PH_FAIL;
		if (phase != PH_FAIL) phase = PH_DONE;
	endfunction

	function automatic void text_in(input logic [7:0] b);
		logic hit;
		if (text_ended || phase == PH_DONE || phase == PH_FAIL) return;
		if (b == 8'h00) begin
			text_ended = 1'b1;
			phase = PH_FAIL;
			return;
		end
		if (phase == PH_PREFIX) begin
			if (prefix_seen >= 4 || b != get_prefix[prefix_seen]) begin
				phase = PH_FAIL;
				return;
			end
			prefix_seen++;
			if (prefix_seen == 4) phase = PH_PATH;
			return;
		end
		if (window_fill >= 9) begin
			uri_byte(window[0]);
			if (phase == PH_FAIL) return;
			for (int i = 0; i < 8; i++) window[i] = window[i + 1];
			window[8] = b;
		end else begin
			window[window_fill] = b;
			window_fill++;
		end
		if (window_fill == 9) begin
			hit = 1'b1;
			for (int i = 0; i < 9; i++)
				if (window[i] != http_marker[i]) hit = 1'b0;
			if (hit) close_uri();
		end
	endfunction

	function automatic void message_end();
		logic ok;
		result_t r;
		ok = (phase == PH_DONE) && cmd_count > 0;
		r.accepted = ok;
		r.ident = ok ? ident_val : 8'h00;
		r.cmd_len = ok ? cmd_count[4:0] : 5'd0;
		r.kind = 1'b0;
		r.final_item = 1'b0;
		if (ok) begin
			for (int i = 0; i < cmd_count; i++) begin
				r.cmd_byte = cmd_store[i];
				result_q.push_back(r);
			end
			runs_accepted++;
		end else begin
			runs_rejected++;
		end
		r.kind = 1'b1;
		r.cmd_byte = 8'h00;
		r.final_item = 1'b1;
		result_q.push_back(r);
		clear_message();
	endfunction

	function automatic void compare_beat();
		result_t e;
		if (result_q.size() == 0) begin
			$error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
				m_axis_tdata, m_axis_tuser, m_axis_tlast);
			errors++;
			return;
		end
		e = result_q.pop_front();
		if (m_axis_tuser !== e.kind) begin
			$error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
			errors++;
		end
		if (m_axis_tdata[7:0] !== e.cmd_byte) begin
			$error("command_byte: expected %h, got %h", e.cmd_byte, m_axis_tdata[7:0]);
			errors++;
		end
		if (m_axis_tdata[8] !== e.accepted) begin
			$error("accepted: expected %0d, got %0d", e.accepted, m_axis_tdata[8]);
			errors++;
		end
		if (m_axis_tdata[16:9] !== e.ident) begin
			$error("ident: expected %0d, got %0d", e.ident, m_axis_tdata[16:9]);
			errors++;
		end
		if (m_axis_tdata[21:17] !== e.cmd_len) begin
			$error("command_length: expected %0d, got %0d", e.cmd_len, m_axis_tdata[21:17]);
			errors++;
		end
		if (m_axis_tlast !== e.final_item) begin
			$error("final_item: expected %0d, got %0d", e.final_item, m_axis_tlast);
			errors++;
		end
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_message();
			result_q.delete();
			errors <= 0;
			runs_accepted <= 0;
			runs_rejected <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				text_in(s_axis_tdata);
				if (s_axis_tlast) message_end();
			end
			if (m_axis_tvalid && m_axis_tready) compare_beat();
		end
	end

endmodule

### sim/http_get_query_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_get_query_parser_tb
// Sends request lines to the parser one byte per beat and lets the checker
// judge every result beat. A directed set covers each rule of the parser,
// then random requests, mostly well formed, some broken, follow.
// ----------------------------------------------------------------------------
module http_get_query_parser_tb;

	typedef logic [7:0] text_q_t[$];

	// A run stops when no beat moves on either side for this many cycles.
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_MESSAGES = 2;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	int errors;
	int pending;
	int runs_accepted;
	int runs_rejected;
	int bytes_sent;
	int idle_cycles;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	logic hold_request;

	http_get_query_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	http_get_query_parser_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors),
		.pending(pending),
		.runs_accepted(runs_accepted),
		.runs_rejected(runs_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: counts cycles in which no beat is taken on either channel.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: mostly ready, short and long stalls, bursts with no stall at
	// all, and one long hold-off when the stimulus asks for it.
	initial begin
		int r;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				hold_request = 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_axis_tready <= 1'b1;
				end else if (r < 70) begin
					m_axis_tready <= 1'b1;
					repeat ($urandom_range(30, 120)) @(negedge clk);
				end else if (r < 96) begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(1, 4)) @(negedge clk);
				end else begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(15, 60)) @(negedge clk);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic void add_text(ref text_q_t q, input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	// Any byte but zero and the given separator.
	function automatic logic [7:0] text_char(input logic [7:0] avoid);
		logic [7:0] c;
		do c = $urandom_range(1, 255); while (c == avoid);
		return c;
	endfunction

	function automatic string id_value();
		string choices[16] = '{"0", "7", "42", "255", "256", "-0", "+9", " 5", "\t1",
			"abc", "1a", "1234", "", "-3", "099", "9"};
		return choices[$urandom_range(0, 15)];
	endfunction

	function automatic string other_key();
		string choices[7] = '{"x", "idd", "cm", "c", "i", "cmdx", "ID"};
		return choices[$urandom_range(0, 6)];
	endfunction

	// Builds one request. Most are well formed with random content; the rest
	// are broken on purpose: bad prefix, missing '?', missing marker, a byte
	// overwritten at random, or cut short.
	function automatic void build_request(ref text_q_t q);
		int flaw;
		int pairs;
		int n;
		logic have_cmd;
		q.delete();
		flaw = $urandom_range(0, 99);
		add_text(q, "GET ");
		if (flaw >= 90 && flaw < 93) q[$urandom_range(0, 3)] = $urandom_range(0, 255);
		q.push_back("/");
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) q.push_back(text_char("?"));
		if (!(flaw >= 93 && flaw < 95)) q.push_back("?");
		pairs = $urandom_range(1, 3);
		have_cmd = 1'b0;
		for (int p = 0; p < pairs; p++) begin
			if (p > 0) q.push_back("&");
			n = $urandom_range(0, 99);
			if (n < 45 || (p == pairs - 1 && !have_cmd && n < 85)) begin
				add_text(q, "cmd=");
				have_cmd = 1'b1;
				// Mostly short commands, a few past the buffer size.
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++) q.push_back(text_char("&"));
			end else if (n < 75) begin
				add_text(q, "id=");
				add_text(q, id_value());
			end else if (n < 95) begin
				add_text(q, other_key());
				q.push_back("=");
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) q.push_back(text_char("&"));
			end else begin
				// Empty key, key with an empty value, or a key with no '='.
				n = $urandom_range(0, 2);
				if (n == 0) add_text(q, "=v");
				else if (n == 1) add_text(q, "cmd=");
				else add_text(q, "cmd");
			end
		end
		if ($urandom_range(0, 9) == 0) q.push_back("&");
		if (!(flaw >= 95 && flaw < 97)) add_text(q, " HTTP/1.1");
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) q.push_back($urandom_range(0, 255));
		if (flaw >= 97) q[$urandom_range(4, q.size() - 1)] = $urandom_range(0, 255);
		if (flaw >= 86 && flaw < 90) begin
			n = $urandom_range(1, q.size());
			while (q.size() > n) void'(q.pop_back());
		end
	endfunction

	// One beat; entered and left at a falling edge, valid still high.
	task automatic send_beat(input logic [7:0] b, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_request(input text_q_t q);
		int gap;
		for (int i = 0; i < q.size(); i++) begin
			send_beat(q[i], i == q.size() - 1);
			gap = pick_gap();
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic send_text(input string s, input logic zero_after);
		text_q_t q;
		add_text(q, s);
		if (zero_after) begin
			q.push_back(8'h00);
			add_text(q, "xyz");
		end
		send_request(q);
	endtask

	initial begin
		text_q_t q;
		string long_cmd;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		hold_request = 1'b0;
		bytes_sent = 0;
		idle_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests, one per rule of the parser.
		send_text("GET /a?id=255&cmd=Z HTTP/1.1\r\n", 1'b0);
		send_text("GET /?cmd=abc&id=-0 HTTP/1.1", 1'b0);
		send_text("GET /p?id= +7&cmd=hi&cmd=ok& HTTP/1.1", 1'b0);
		// Hold off the receiver once while the long command and the requests
		// after it keep coming, so that the result path backs up and input
		// is stalled.
		hold_request = 1'b1;
		long_cmd = "GET /?cmd=";
		for (int i = 0; i < 34; i++) long_cmd = {long_cmd, "q"};
		send_text({long_cmd, " HTTP/1.1"}, 1'b0);
		send_text("XET /?cmd=a HTTP/1.1", 1'b0);
		send_text("GET /?cmd=a", 1'b0);
		send_text("GET /cmd=a HTTP/1.1", 1'b0);
		send_text("GET /?cmd HTTP/1.1", 1'b0);
		send_text("GET /?cmd=a&& HTTP/1.1", 1'b0);
		send_text("GET /?=a&cmd=b HTTP/1.1", 1'b0);
		send_text("GET /?cmd= HTTP/1.1", 1'b0);
		send_text("GET /?id=1234&cmd=a HTTP/1.1", 1'b0);
		send_text("GET /?id=1a&cmd=a HTTP/1.1", 1'b0);
		send_text("GET /?id=256&cmd=a HTTP/1.1", 1'b0);
		send_text("GET /?x=1 HTTP/1.1", 1'b0);
		send_text("GET /?cmd=ab", 1'b1);
		q.delete();
		q.push_back(8'hFF);
		send_request(q);

		// Let every result drain before the random part.
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (int m = 0; m < RANDOM_MESSAGES; m++) begin
			// Pause the sender once more until the results have drained.
			if (m == 1) begin
				s_axis_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			build_request(q);
			send_request(q);
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (100) @(negedge clk);
		$display("covered %0d request bytes in %0d messages (%0d accepted, %0d rejected)",
			bytes_sent, runs_accepted + runs_rejected, runs_accepted, runs_rejected);
		$display("with random idle gaps on input and stalls on output, one long hold-off");
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/hgq_pkg.sv
hw/rtl/hgq_datapath.sv
hw/rtl/hgq_ctrl.sv
hw/rtl/http_get_query_parser.sv
sim/http_get_query_parser_checker.sv
sim/http_get_query_parser_tb.sv
